/* rtl/core/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while the block is out of reset
`define DTYP_CHECK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dtyp check failed");

// property checked at every edge, reset cycles included
`define DTYP_CHECK_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dtyp check failed");

`endif

/* rtl/core/dtyp_pkg.sv */
// shared widths, constants, types and the arctangent table of the yaw/pitch block
package dtyp_pkg;

  localparam int CORDIC_STEPS = 20;
  localparam int COORD_WIDTH  = 32;

  // port field widths
  localparam int IN_W    = 32;
  localparam int YAW_W   = 26;
  localparam int PITCH_W = 24;

  // inputs are read as two's complement below 33 bits, as unsigned above
  localparam bit COORD_SIGNED = (COORD_WIDTH <= IN_W);
  localparam int VALID_BITS   = COORD_SIGNED ? COORD_WIDTH : IN_W;
  localparam int SIGN_BIT     = VALID_BITS - 1;

  // internal widths
  localparam int CW       = IN_W + 2;               // coordinate, room for negation
  localparam int MW       = IN_W + 1;               // magnitude
  localparam int NORM_TOP = 48;                     // normalised msb position
  localparam int DW       = NORM_TOP + 6;           // cordic datapath
  localparam int SW       = $clog2(NORM_TOP + 1);   // shift amount
  localparam int AW       = 36;                     // angle, 2^32 = 45 degrees
  localparam int SIW      = $clog2(CORDIC_STEPS);   // step index

  localparam int PIPE_STAGES = 2 * CORDIC_STEPS + 6;

  // gain correction 1/K in q30
  localparam int FRAC   = 30;
  localparam int INVK_W = 30;
  localparam logic [INVK_W-1:0] INVK = INVK_W'(652032874);

  localparam logic [63:0] PI4_Q60 = 64'h0C90FDAA22168C23;

  localparam logic signed [AW-1:0] ANG_TWO = AW'(64'h2_0000_0000);

  // degree conversion
  localparam int DEG_MUL    = 45;
  localparam int DEG_FRAC   = 16;
  localparam int DEG_ROUND  = 1 << (DEG_FRAC - 1);
  localparam int DEG90_Q16  = 5898240;
  localparam int DEG270_Q16 = 17694720;

  typedef struct packed {
    logic zero;
    logic flat;
    logic y_neg;
    logic y_pos;
  } flags_t;

  // sideband travelling next to the cordic datapath
  typedef struct packed {
    flags_t                 fl;
    logic signed [CW-1:0]   b;
    logic [SW-1:0]          t;
    logic [SW-1:0]          d;
    logic signed [AW-1:0]   yaw_a;
  } side_t;

  // floor(2^32 * atan(2^-i) / (pi/4)) from a q60 series, one entry per step
  function automatic logic [CORDIC_STEPS*AW-1:0] atan_table();
    logic [CORDIC_STEPS*AW-1:0] tab;
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] term;
    int unsigned e;
    int unsigned dv;
    tab = '0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      r = '0;
      q = '0;
      if (i == 0) begin
        q = 64'd1 << 32;
      end else begin
        for (int k = 0; k < 31; k++) begin
          e  = i * (2 * k + 1);
          dv = 2 * k + 1;
          if (e <= 60) begin
            term = (64'd1 << 60) >> e;
            term = term / 64'(dv);
            if ((k & 1) != 0) r = r - term;
            else r = r + term;
          end
        end
        for (int n = 0; n < 32; n++) begin
          r = r << 1;
          q = q << 1;
          if (r >= PI4_Q60) begin
            r = r - PI4_Q60;
            q = q | 64'd1;
          end
        end
      end
      tab[i*AW +: AW] = AW'(q);
    end
    return tab;
  endfunction

  localparam logic [CORDIC_STEPS*AW-1:0] ATAN_TAB = atan_table();

endpackage

/* rtl/core/dtyp_vec_if.sv */
// request channel carrying one direction vector
interface dtyp_vec_if;
  import dtyp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] x_coord;
  logic signed [IN_W-1:0] y_coord;
  logic signed [IN_W-1:0] z_coord;

  modport source (output valid, output x_coord, output y_coord, output z_coord,
                  input ready);
  modport sink   (input valid, input x_coord, input y_coord, input z_coord,
                  output ready);
endinterface

/* rtl/core/dtyp_ang_if.sv */
// result channel carrying yaw, pitch and the zero vector flag
interface dtyp_ang_if;
  import dtyp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [YAW_W-1:0]   yaw_deg;
  logic signed [PITCH_W-1:0] pitch_deg;
  logic                      zero_vector;

  modport source (output valid, output yaw_deg, output pitch_deg, output zero_vector,
                  input ready);
  modport sink   (input valid, input yaw_deg, input pitch_deg, input zero_vector,
                  output ready);
endinterface

/* rtl/core/dtyp_cordic_cell.sv */
// one vectoring cordic iteration with its output register
module dtyp_cordic_cell (
  input  logic                           clk,
  input  logic                           en,
  input  logic [dtyp_pkg::SIW-1:0]       step,
  input  logic signed [dtyp_pkg::DW-1:0] x_in,
  input  logic signed [dtyp_pkg::DW-1:0] y_in,
  input  logic signed [dtyp_pkg::AW-1:0] a_in,
  output logic signed [dtyp_pkg::DW-1:0] x_out,
  output logic signed [dtyp_pkg::DW-1:0] y_out,
  output logic signed [dtyp_pkg::AW-1:0] a_out
);
  import dtyp_pkg::*;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [AW-1:0] ang;

  always_comb begin
    dx  = y_in >>> step;
    dy  = x_in >>> step;
    ang = $signed(ATAN_TAB[int'(step)*AW +: AW]);
  end

  // turn clockwise while y is not negative
  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[DW-1]) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        a_out <= a_in + ang;
      end else begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        a_out <= a_in - ang;
      end
    end
  end
endmodule

/* rtl/core/dtyp_chain.sv */
// row of cordic cells with the sideband shifted alongside
module dtyp_chain (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [dtyp_pkg::DW-1:0] x_in,
  input  logic signed [dtyp_pkg::DW-1:0] y_in,
  input  logic signed [dtyp_pkg::AW-1:0] a_in,
  input  dtyp_pkg::side_t                side_in,
  output logic signed [dtyp_pkg::DW-1:0] x_out,
  output logic signed [dtyp_pkg::AW-1:0] a_out,
  output dtyp_pkg::side_t                side_out
);
  import dtyp_pkg::*;

  logic signed [DW-1:0] xs [CORDIC_STEPS+1];
  logic signed [DW-1:0] ys [CORDIC_STEPS+1];
  logic signed [AW-1:0] as [CORDIC_STEPS+1];
  side_t                sd [CORDIC_STEPS+1];

  assign xs[0] = x_in;
  assign ys[0] = y_in;
  assign as[0] = a_in;
  assign sd[0] = side_in;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    dtyp_cordic_cell u_cell (
      .clk   (clk),
      .en    (en),
      .step  (SIW'(i)),
      .x_in  (xs[i]),
      .y_in  (ys[i]),
      .a_in  (as[i]),
      .x_out (xs[i+1]),
      .y_out (ys[i+1]),
      .a_out (as[i+1])
    );

    always_ff @(posedge clk) begin
      if (en) sd[i+1] <= sd[i];
    end
  end

  // final y residue is not needed downstream
  logic y_last_neg;
  assign y_last_neg = ys[CORDIC_STEPS][DW-1];

  assign x_out    = xs[CORDIC_STEPS];
  assign a_out    = as[CORDIC_STEPS];
  assign side_out = y_last_neg ? sd[CORDIC_STEPS] : sd[CORDIC_STEPS];
endmodule

/* rtl/core/dtyp_norm.sv */
// front end: magnitudes, shift search, normalising shift and half plane turn
module dtyp_norm (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [dtyp_pkg::IN_W-1:0] x_coord,
  input  logic signed [dtyp_pkg::IN_W-1:0] y_coord,
  input  logic signed [dtyp_pkg::IN_W-1:0] z_coord,
  output logic signed [dtyp_pkg::DW-1:0]   x_out,
  output logic signed [dtyp_pkg::DW-1:0]   y_out,
  output logic signed [dtyp_pkg::AW-1:0]   a_out,
  output dtyp_pkg::side_t                  side_out
);
  import dtyp_pkg::*;

  function automatic logic signed [CW-1:0] to_coord(input logic [IN_W-1:0] v);
    logic [CW-1:0] r;
    for (int j = 0; j < IN_W; j++)
      r[j] = (j < VALID_BITS) ? v[j] : (COORD_SIGNED ? v[SIGN_BIT] : 1'b0);
    for (int j = IN_W; j < CW; j++)
      r[j] = COORD_SIGNED ? v[SIGN_BIT] : 1'b0;
    return $signed(r);
  endfunction

  // left shift that puts the msb at NORM_TOP, capped at NORM_TOP
  function automatic logic [SW-1:0] norm_shift(input logic [MW-1:0] m);
    logic [SW-1:0] s;
    s = SW'(NORM_TOP);
    for (int j = 0; j < MW; j++)
      if (m[j]) s = (j >= NORM_TOP) ? '0 : SW'(NORM_TOP - j);
    return s;
  endfunction

  // stage 1: magnitudes and flags
  logic signed [CW-1:0] xc, yc, zc;
  logic [MW-1:0]        ax, az, ay;
  flags_t               fl_c;

  always_comb begin
    xc = to_coord(x_coord);
    yc = to_coord(y_coord);
    zc = to_coord(z_coord);
    ax = xc[CW-1] ? MW'(-xc) : MW'(xc);
    az = zc[CW-1] ? MW'(-zc) : MW'(zc);
    ay = yc[CW-1] ? MW'(-yc) : MW'(yc);
    fl_c.flat  = (xc == '0) && (zc == '0);
    fl_c.zero  = fl_c.flat && (yc == '0);
    fl_c.y_neg = yc[CW-1];
    fl_c.y_pos = !yc[CW-1] && (yc != '0);
  end

  logic signed [CW-1:0] x1, y1, z1;
  logic [MW-1:0]        m1, ab1;
  flags_t               fl1;

  always_ff @(posedge clk) begin
    if (en) begin
      x1  <= xc;
      y1  <= yc;
      z1  <= zc;
      m1  <= (ax > az) ? ax : az;
      ab1 <= ay;
      fl1 <= fl_c;
    end
  end

  // stage 2: shift search on both magnitudes
  logic signed [CW-1:0] x2, y2, z2;
  logic [SW-1:0]        s2, u2;
  logic                 abz2;
  flags_t               fl2;

  always_ff @(posedge clk) begin
    if (en) begin
      x2   <= x1;
      y2   <= y1;
      z2   <= z1;
      s2   <= norm_shift(m1);
      u2   <= norm_shift(ab1);
      abz2 <= (ab1 == '0);
      fl2  <= fl1;
    end
  end

  // stage 3: shift and turn into the right half plane
  logic [SW-1:0]        u, t;
  logic signed [DW-1:0] xv, zv, xr, yr;
  logic signed [AW-1:0] a0;
  side_t                sd_c;

  always_comb begin
    u  = abz2 ? s2 : u2;
    t  = (u < s2) ? u : s2;
    xv = DW'(x2) <<< s2;
    zv = DW'(z2) <<< s2;
    if (xv[DW-1]) begin
      if (!zv[DW-1]) begin
        xr = zv;
        yr = -xv;
        a0 = ANG_TWO;
      end else begin
        xr = -zv;
        yr = xv;
        a0 = -ANG_TWO;
      end
    end else begin
      xr = xv;
      yr = zv;
      a0 = '0;
    end
    sd_c.fl    = fl2;
    sd_c.b     = -y2;
    sd_c.t     = t;
    sd_c.d     = s2 - t;
    sd_c.yaw_a = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= xr;
      y_out    <= yr;
      a_out    <= a0;
      side_out <= sd_c;
    end
  end
endmodule

/* rtl/core/dtyp_gain.sv */
// gain correction of the horizontal length and setup of the pitch vector
module dtyp_gain (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [dtyp_pkg::DW-1:0] h_in,
  input  logic signed [dtyp_pkg::AW-1:0] a_in,
  input  dtyp_pkg::side_t                side_in,
  output logic signed [dtyp_pkg::DW-1:0] hx,
  output logic signed [dtyp_pkg::DW-1:0] by,
  output dtyp_pkg::side_t                side_out
);
  import dtyp_pkg::*;

  localparam int PHW = DW - FRAC + INVK_W;
  localparam int PLW = FRAC + INVK_W;

  logic [PHW-1:0] p_hi;
  logic [PLW-1:0] p_lo;
  side_t          side_c;
  side_t          side1;

  // yaw angle joins the sideband here
  always_comb begin
    side_c       = side_in;
    side_c.yaw_a = a_in;
  end

  // length split at bit 30, both halves times 1/K
  always_ff @(posedge clk) begin
    if (en) begin
      p_hi  <= PHW'(h_in[DW-1:FRAC]) * PHW'(INVK);
      p_lo  <= PLW'(h_in[FRAC-1:0]) * PLW'(INVK);
      side1 <= side_c;
    end
  end

  logic [DW-1:0] hk;
  side_t         side2;

  always_ff @(posedge clk) begin
    if (en) begin
      hk    <= DW'(p_hi + PHW'(p_lo[PLW-1:FRAC]));
      side2 <= side1;
    end
  end

  // common scale for length and height
  always_ff @(posedge clk) begin
    if (en) begin
      hx       <= $signed(hk >> side2.d);
      by       <= DW'(side2.b) <<< side2.t;
      side_out <= side2;
    end
  end
endmodule

/* rtl/core/direction_to_yaw_pitch_top.sv */
// top level of the direction vector to yaw and pitch converter
//
// usage
//   vec    : request channel, one direction vector (x, y, z, signed q16.16) per request
//   angles : result channel, yaw and pitch in degrees with 16 fraction bits and a flag
//            for the all-zero vector; exactly one result per request, in order
//   yaw is atan2(z, x) minus 90 degrees, pitch is atan2(-y, horizontal length)
// timing
//   a request passes the front end, the yaw chain, the gain stages and the pitch chain
//   into the output register; one request per cycle sustained while results are taken:
//   every iteration of both cordic chains is its own cell: depth sets the latency only
// reset
//   synchronous rst empties the pipeline and drops angles.valid; no other state
// stall
//   a result held on angles while the receiver is not ready stays put; the pipeline
//   keeps moving and taking requests until a finished result reaches the last stage,
//   then everything holds until the output register is drained
module direction_to_yaw_pitch_top (
  input  logic      clk,
  input  logic      rst,
  dtyp_vec_if.sink  vec,
  dtyp_ang_if.source angles
);
  import dtyp_pkg::*;

  localparam int PW    = AW + 7;      // angle times 45 plus rounding
  localparam int DEG_W = PW - DEG_FRAC;

  localparam logic signed [DEG_W-1:0] YAW_LO   = DEG_W'(-DEG270_Q16);
  localparam logic signed [DEG_W-1:0] YAW_HI   = DEG_W'(DEG90_Q16);
  localparam logic signed [DEG_W-1:0] PITCH_LO = DEG_W'(-DEG90_Q16);
  localparam logic signed [DEG_W-1:0] PITCH_HI = DEG_W'(DEG90_Q16);

  // angle units of 45/2^32 degree to degrees q16, round half up, clamped
  function automatic logic signed [DEG_W-1:0] to_deg(input logic signed [AW-1:0] a,
                                                    input logic signed [DEG_W-1:0] lo,
                                                    input logic signed [DEG_W-1:0] hi);
    logic signed [PW-1:0]    p;
    logic signed [DEG_W-1:0] d;
    p = PW'(a) * PW'(DEG_MUL) + PW'(DEG_ROUND);
    d = DEG_W'(p >>> DEG_FRAC);
    if (d < lo) d = lo;
    else if (d > hi) d = hi;
    return d;
  endfunction

  // pipeline control: one valid bit per stage, stall only when the last stage
  // holds a result the output register cannot take
  logic [PIPE_STAGES-1:0] vld;
  logic                   out_load;
  logic                   en;

  assign out_load  = !angles.valid || angles.ready;
  assign en        = out_load || !vld[PIPE_STAGES-1];
  assign vec.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_STAGES-2:0], vec.valid};
    end
  end

  // front end and yaw chain
  logic signed [DW-1:0] yx0, yy0, yx1;
  logic signed [AW-1:0] ya0, ya1;
  side_t                ys0, ys1;

  dtyp_norm u_norm (
    .clk      (clk),
    .en       (en),
    .x_coord  (vec.x_coord),
    .y_coord  (vec.y_coord),
    .z_coord  (vec.z_coord),
    .x_out    (yx0),
    .y_out    (yy0),
    .a_out    (ya0),
    .side_out (ys0)
  );

  dtyp_chain u_yaw (
    .clk      (clk),
    .en       (en),
    .x_in     (yx0),
    .y_in     (yy0),
    .a_in     (ya0),
    .side_in  (ys0),
    .x_out    (yx1),
    .a_out    (ya1),
    .side_out (ys1)
  );

  // length correction and pitch chain
  logic signed [DW-1:0] px0, py0, px1;
  logic signed [AW-1:0] pa1;
  side_t                ps0, ps1;

  dtyp_gain u_gain (
    .clk      (clk),
    .en       (en),
    .h_in     (yx1),
    .a_in     (ya1),
    .side_in  (ys1),
    .hx       (px0),
    .by       (py0),
    .side_out (ps0)
  );

  // final pitch length is not needed
  dtyp_chain u_pitch (
    .clk      (clk),
    .en       (en),
    .x_in     (px0),
    .y_in     (py0),
    .a_in     ('0),
    .side_in  (ps0),
    .x_out    (px1),
    .a_out    (pa1),
    .side_out (ps1)
  );

  // degree conversion and the cases with no horizontal part
  logic signed [DEG_W-1:0] yaw_d, pitch_d;

  always_comb begin
    if (ps1.fl.flat) begin
      yaw_d = '0;
      priority if (ps1.fl.y_neg) pitch_d = PITCH_HI;
      else if (ps1.fl.y_pos) pitch_d = PITCH_LO;
      else pitch_d = '0;
    end else begin
      yaw_d   = to_deg(ps1.yaw_a - ANG_TWO, YAW_LO, YAW_HI);
      pitch_d = to_deg(pa1, PITCH_LO, PITCH_HI);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      angles.valid <= 1'b0;
    end else if (out_load) begin
      angles.valid <= vld[PIPE_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && vld[PIPE_STAGES-1]) begin
      angles.yaw_deg     <= YAW_W'(yaw_d);
      angles.pitch_deg   <= PITCH_W'(pitch_d);
      angles.zero_vector <= ps1.fl.zero;
    end
  end
endmodule

/* rtl/core/dtyp_checker.sv */
// port checker for the yaw/pitch block and its bind
`include "assert_macros.svh"

module dtyp_checker (
  input logic        clk,
  input logic        rst,
  dtyp_vec_if.sink   vec,
  dtyp_ang_if.source angles
);
  import dtyp_pkg::*;

  `DTYP_CHECK(a_out_hold, clk, rst, angles.valid && !angles.ready |=> angles.valid)

  `DTYP_CHECK(a_out_stable, clk, rst, angles.valid && !angles.ready |=> $stable(angles.yaw_deg) && $stable(angles.pitch_deg) && $stable(angles.zero_vector))

  `DTYP_CHECK_ALWAYS(a_reset_empty, clk, rst |=> !angles.valid)

  `DTYP_CHECK(a_ready_when_empty, clk, rst, !angles.valid |-> vec.ready)

  `DTYP_CHECK(a_zero_result, clk, rst, angles.valid && angles.zero_vector |-> angles.yaw_deg == '0 && angles.pitch_deg == '0 && angles.yaw_deg >= -DEG270_Q16 && angles.yaw_deg <= DEG90_Q16)

endmodule

bind direction_to_yaw_pitch_top dtyp_checker u_dtyp_checker (
  .clk    (clk),
  .rst    (rst),
  .vec    (vec),
  .angles (angles)
);
